/* design/b58e_pkg.sv */
// Shared types, sizes and the character table of the base58 encoder.
package b58e_pkg;

  // Sizes of the byte chain and the digit stack.
  localparam int MAX_BYTES  = 32;
  localparam int MAX_DIGITS = 44;
  localparam int RADIX      = 58;
  // Upper bound on digits counted during one conversion.
  localparam int SCRATCH    = 64;

  // Derived widths.
  localparam int BCW = $clog2(MAX_BYTES + 1);
  localparam int DCW = $clog2(MAX_DIGITS + 1);
  localparam int TW  = $clog2(MAX_BYTES + SCRATCH + 1);

  // Character table, first character in the top byte.
  localparam logic [8*58-1:0] B58_ALPHABET =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  // Input request: one byte of the big-endian number.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } b58e_in_t;

  // Output request: one character of the encoding.
  typedef struct packed {
    logic [6:0] out_char;
    logic       last_char;
    logic       overflow;
  } b58e_out_t;

  // Control of the byte chain.
  typedef struct packed {
    logic write;
    logic shift;
  } b58e_bctl_t;

  // Control of the digit stack.
  typedef struct packed {
    logic push;
    logic pop;
  } b58e_dctl_t;

  // Maps a digit value to its 7-bit ASCII character.
  function automatic logic [6:0] b58_char(input logic [5:0] d);
    logic [7:0] ch;
    if (d < 6'd58) begin
      ch = B58_ALPHABET[8*(57 - int'(d)) +: 8];
    end else begin
      ch = "1";
    end
    return ch[6:0];
  endfunction

endpackage

/* design/base58_encoder_top.sv */
// Top level of the base58 encoder: control, byte chain, divider and digit stack.
//
//  Port group   Direction  Carries
//  in_*         input      one byte of the number, flag on its final byte
//  out_*        output     one alphabet character, final flag, overflow flag
//
// One byte is taken per cycle while the block is loading. After the final byte,
// each base58 digit takes one pass of the running remainder along the chain
// through the single divide-by-58 unit, and a last check finds the number
// exhausted. Characters then leave at one per cycle while the output is not
// stalled. Reset clears the control state only; the chain contents need none.
// A stalled output holds the character in the output register and pauses the
// emission; the next number may be loaded while the final one waits.
module base58_encoder_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  b58e_pkg::b58e_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output b58e_pkg::b58e_out_t out_data
);

  localparam int BCW = b58e_pkg::BCW;
  localparam int DCW = b58e_pkg::DCW;
  localparam int TW  = b58e_pkg::TW;
  localparam int MB  = b58e_pkg::MAX_BYTES;
  localparam int MD  = b58e_pkg::MAX_DIGITS;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]     state_r, state_nxt;
  logic [BCW-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [BCW-1:0] zpc_r, zpc_nxt;
  logic           in_zp_r, in_zp_nxt;
  logic           drop_r, drop_nxt;
  logic [BCW-1:0] pos_r, pos_nxt;
  logic [5:0]     rem_r, rem_nxt;
  logic           nzacc_r, nzacc_nxt;
  logic           numnz_r, numnz_nxt;
  logic [TW-1:0]  ndig_r, ndig_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic [TW-1:0]  pad_r, pad_nxt;
  logic [TW-1:0]  left_r, left_nxt;
  logic           ovf_r, ovf_nxt;
  logic           out_valid_r, out_valid_nxt;
  b58e_pkg::b58e_out_t out_data_r, out_data_nxt;

  logic           in_acc;
  logic           room;
  logic           store;
  logic [5:0]     rem_in;
  logic [7:0]     quot;
  logic [5:0]     rem_out;
  logic           pass_end;
  logic           conv_done;
  logic           step;
  logic [TW-1:0]  total;
  logic           emit_ld;
  logic [BCW-1:0] target;
  logic [7:0]     new_byte;
  logic [6:0]     emit_char;

  b58e_pkg::b58e_bctl_t bctl;
  b58e_pkg::b58e_dctl_t dctl;

  logic [7:0] byte_q  [MB];
  logic [5:0] digit_q [MD];

  // Handshake and step conditions.
  assign in_ready  = (state_r == ST_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign room      = (byte_cnt_r < BCW'(MB));
  assign store     = in_acc && room;
  assign rem_in    = (pos_r == '0) ? 6'd0 : rem_r;
  assign pass_end  = (pos_r == byte_cnt_r - BCW'(1));
  assign conv_done = (state_r == ST_CONV) && (pos_r == '0) &&
                     (!numnz_r || ndig_r == TW'(b58e_pkg::SCRATCH));
  assign step      = (state_r == ST_CONV) && !conv_done;
  assign total     = TW'(zpc_r) + ndig_r;
  assign emit_ld   = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  // Divider at the head of the byte chain.
  b58e_div58 u_div (
    .rem_in  (rem_in),
    .byte_in (byte_q[0]),
    .quot    (quot),
    .rem_out (rem_out)
  );

  // Byte chain: loading writes at the fill point, a division step rotates the
  // stored bytes towards the head and writes the quotient at the tail.
  assign bctl.write = store || step;
  assign bctl.shift = step;
  assign target     = (state_r == ST_CONV) ? byte_cnt_r - BCW'(1) : byte_cnt_r;
  assign new_byte   = (state_r == ST_CONV) ? quot : in_data.data_byte;

  for (genvar i = 0; i < MB; i++) begin : g_byte
    logic [7:0] nb;
    if (i == MB - 1) begin : g_tail
      assign nb = 8'd0;
    end else begin : g_mid
      assign nb = byte_q[i+1];
    end
    b58e_byte_cell u_cell (
      .clk       (clk),
      .ctl       (bctl),
      .sel       (target == BCW'(i)),
      .new_byte  (new_byte),
      .next_byte (nb),
      .byte_q    (byte_q[i])
    );
  end

  // Digit stack: remainders are pushed least significant first and popped
  // most significant first.
  assign dctl.push = step && pass_end && (dcnt_r < DCW'(MD));
  assign dctl.pop  = emit_ld && (pad_r == '0);

  for (genvar j = 0; j < MD; j++) begin : g_digit
    logic [5:0] pd;
    logic [5:0] nd;
    if (j == 0) begin : g_top
      assign pd = rem_out;
    end else begin : g_inner
      assign pd = digit_q[j-1];
    end
    if (j == MD - 1) begin : g_bottom
      assign nd = 6'd0;
    end else begin : g_upper
      assign nd = digit_q[j+1];
    end
    b58e_digit_cell u_cell (
      .clk        (clk),
      .ctl        (dctl),
      .prev_digit (pd),
      .next_digit (nd),
      .digit_q    (digit_q[j])
    );
  end

  // Leading ones come first, then the stacked digits.
  assign emit_char = (pad_r != '0) ? b58e_pkg::b58_char(6'd0)
                                   : b58e_pkg::b58_char(digit_q[0]);

  // Sequencer: load, convert, emit.
  always_comb begin
    state_nxt    = state_r;
    byte_cnt_nxt = byte_cnt_r;
    zpc_nxt      = zpc_r;
    in_zp_nxt    = in_zp_r;
    drop_nxt     = drop_r;
    pos_nxt      = pos_r;
    rem_nxt      = rem_r;
    nzacc_nxt    = nzacc_r;
    numnz_nxt    = numnz_r;
    ndig_nxt     = ndig_r;
    dcnt_nxt     = dcnt_r;
    pad_nxt      = pad_r;
    left_nxt     = left_r;
    ovf_nxt      = ovf_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (room) begin
            byte_cnt_nxt = byte_cnt_r + BCW'(1);
            if (in_zp_r && in_data.data_byte == 8'd0) begin
              zpc_nxt = zpc_r + BCW'(1);
            end else begin
              in_zp_nxt = 1'b0;
            end
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_data.last_byte) begin
            state_nxt = ST_CONV;
            pos_nxt   = '0;
            nzacc_nxt = 1'b0;
            ndig_nxt  = '0;
            dcnt_nxt  = '0;
            numnz_nxt = !in_zp_nxt;
          end
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          state_nxt = ST_EMIT;
          left_nxt  = (total > TW'(MD)) ? TW'(MD) : total;
          pad_nxt   = total - TW'(dcnt_r);
          ovf_nxt   = drop_r || (total > TW'(MD));
        end else if (pass_end) begin
          // Last byte of this pass: the remainder is the next digit.
          pos_nxt   = '0;
          ndig_nxt  = ndig_r + TW'(1);
          if (dcnt_r < DCW'(MD)) begin
            dcnt_nxt = dcnt_r + DCW'(1);
          end
          numnz_nxt = nzacc_r || (quot != 8'd0);
          nzacc_nxt = 1'b0;
        end else begin
          pos_nxt   = pos_r + BCW'(1);
          rem_nxt   = rem_out;
          nzacc_nxt = nzacc_r || (quot != 8'd0);
        end
      end
      ST_EMIT: begin
        if (emit_ld) begin
          left_nxt = left_r - TW'(1);
          if (pad_r != '0) begin
            pad_nxt = pad_r - TW'(1);
          end
          if (left_r == TW'(1)) begin
            state_nxt    = ST_LOAD;
            byte_cnt_nxt = '0;
            zpc_nxt      = '0;
            in_zp_nxt    = 1'b1;
            drop_nxt     = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit_ld) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.out_char  = emit_char;
      out_data_nxt.last_char = (left_r == TW'(1));
      out_data_nxt.overflow  = ovf_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      byte_cnt_r  <= '0;
      zpc_r       <= '0;
      in_zp_r     <= 1'b1;
      drop_r      <= 1'b0;
      pos_r       <= '0;
      nzacc_r     <= 1'b0;
      numnz_r     <= 1'b0;
      ndig_r      <= '0;
      dcnt_r      <= '0;
      pad_r       <= '0;
      left_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      zpc_r       <= zpc_nxt;
      in_zp_r     <= in_zp_nxt;
      drop_r      <= drop_nxt;
      pos_r       <= pos_nxt;
      nzacc_r     <= nzacc_nxt;
      numnz_r     <= numnz_nxt;
      ndig_r      <= ndig_nxt;
      dcnt_r      <= dcnt_nxt;
      pad_r       <= pad_nxt;
      left_r      <= left_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/b58e_div58.sv */
// Divides a two-place radix-256 remainder word by 58.
module b58e_div58 (
  input  logic [5:0] rem_in,
  input  logic [7:0] byte_in,
  output logic [7:0] quot,
  output logic [5:0] rem_out
);

  logic [13:0] cur;
  logic [24:0] prod;
  logic [13:0] back;

  // The word is below 58*256, so the reciprocal 1130/2^16 gives an exact quotient.
  assign cur     = {rem_in, byte_in};
  assign prod    = 25'(cur) * 25'd1130;
  assign quot    = prod[23:16];
  assign back    = 14'(quot) * 14'(b58e_pkg::RADIX);
  assign rem_out = 6'(cur - back);

endmodule

/* design/b58e_byte_cell.sv */
// One cell of the byte chain that holds the number during conversion.
module b58e_byte_cell (
  input  logic                clk,
  input  b58e_pkg::b58e_bctl_t ctl,
  input  logic                sel,
  input  logic [7:0]          new_byte,
  input  logic [7:0]          next_byte,
  output logic [7:0]          byte_q
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  // A shift moves the neighbour's byte in; the selected cell takes the new byte.
  always_comb begin
    byte_nxt = byte_r;
    if (ctl.shift) begin
      byte_nxt = sel ? new_byte : next_byte;
    end else if (ctl.write && sel) begin
      byte_nxt = new_byte;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_q = byte_r;

endmodule

/* design/b58e_digit_cell.sv */
// One cell of the digit stack: push moves digits deeper, pop brings them up.
module b58e_digit_cell (
  input  logic                clk,
  input  b58e_pkg::b58e_dctl_t ctl,
  input  logic [5:0]          prev_digit,
  input  logic [5:0]          next_digit,
  output logic [5:0]          digit_q
);

  logic [5:0] digit_r;
  logic [5:0] digit_nxt;

  // Each cell takes from the cell above on a push and from below on a pop.
  always_comb begin
    digit_nxt = digit_r;
    if (ctl.push) begin
      digit_nxt = prev_digit;
    end else if (ctl.pop) begin
      digit_nxt = next_digit;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit_q = digit_r;

endmodule
